// File: rtl/text_terminal_writer_assert.svh
// Assertion helpers for the terminal RTL. They expect clk and rst_n in scope.
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

// condition holds at every edge out of reset
`define TTW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ttw_pkg.sv
package ttw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  // port field widths
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int COLF_W = 7;
  localparam int ROWF_W = 5;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int TAB_STEP = 4;

  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h04;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    K_PRINT,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_NOP,
    K_READ,
    K_READ_OUT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // logical row plus offset, folded back into 0..ROWS-1
  function automatic logic [ROW_W-1:0] row_wrap(logic [ROW_W:0] s);
    logic [ROW_W:0] lim;
    lim = (ROW_W+1)'(ROWS);
    if (s >= lim) begin
      row_wrap = ROW_W'(s - lim);
    end else begin
      row_wrap = ROW_W'(s);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] prow,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// File: rtl/text_terminal_writer.sv
// Put and out-of-range read: front hold register, then queue slot, then result register.
// In-range read: an extra S_READ state for the registered cell memory read.
// Scroll: S_BLANK blanks the recycled row, COLUMNS (80) cells; rows rotate, no screen copy.
// Throughput: one put per cycle; out_stall, a scroll or an in-range read (S_READ) stalls it.
// Reset: cursor home, color 4, then a clearing pass over all ROWS*COLUMNS (2000) cells
// writes blank cells while in_stall stays high; config writes are still taken.
module text_terminal_writer import ttw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_text_color,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COLF_W-1:0] in_read_column,
  input  logic [ROWF_W-1:0] in_read_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_cell_written,
  output logic [COLF_W-1:0] out_cursor_column,
  output logic [ROWF_W-1:0] out_cursor_row,
  output logic              out_scrolled
);

  logic [CHAR_W-1:0] text_color_r, text_color_nxt;
  logic              clearing;
  logic              f_valid, f_stall;
  cmd_t              f_cmd;
  logic              q_valid, q_stall;
  cmd_t              q_cmd;

  assign text_color_nxt = cfg_we ? cfg_text_color : text_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  ttw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing       (clearing),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_read_column (in_read_column),
    .in_read_row    (in_read_row),
    .cmd_valid      (f_valid),
    .cmd            (f_cmd),
    .cmd_stall      (f_stall)
  );

  ttw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_stall (f_stall),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_stall  (q_stall)
  );

  ttw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .text_color        (text_color_r),
    .clearing          (clearing),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_stall           (q_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_data     (out_cell_data),
    .out_cell_written  (out_cell_written),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_scrolled      (out_scrolled)
  );

endmodule

// File: rtl/ttw_front.sv
module ttw_front import ttw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COLF_W-1:0] in_read_column,
  input  logic [ROWF_W-1:0] in_read_row,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_stall
);

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r, hold_nxt;
  cmd_t cls;
  logic accept;
  logic in_range;

  assign in_stall = clearing || (hold_valid_r && cmd_stall);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_read_column) < COLUMNS) && (32'(in_read_row) < ROWS);

  always_comb begin
    cls.char_code = in_char_code;
    cls.col       = COL_W'(in_read_column);
    cls.row       = ROW_W'(in_read_row);
    if (in_operation == OP_READ) begin
      cls.kind = in_range ? K_READ : K_READ_OUT;
    end else begin
      unique case (in_char_code)
        CH_LF:          cls.kind = K_NEWLINE;
        CH_CR:          cls.kind = K_RETURN;
        CH_TAB:         cls.kind = K_TAB;
        CH_NUL, CH_BEL: cls.kind = K_NOP;
        default:        cls.kind = K_PRINT;
      endcase
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = cls;
    end else if (!cmd_stall) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign cmd_valid = hold_valid_r;
  assign cmd       = hold_r;

endmodule

// File: rtl/ttw_queue.sv
module ttw_queue import ttw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_stall,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_stall
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_stall = (count_r == QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_comb begin
    wptr_nxt  = push ? QPTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = pop  ? QPTR_W'(rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/ttw_back.sv
`include "text_terminal_writer_assert.svh"

module ttw_back import ttw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] text_color,
  output logic              clearing,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_cell_written,
  output logic [COLF_W-1:0] out_cursor_column,
  output logic [ROWF_W-1:0] out_cursor_row,
  output logic              out_scrolled
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_RUN   = 4'b0010,
    S_READ  = 4'b0100,
    S_BLANK = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;       // physical row holding logical row 0
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_data_r, out_data_nxt;
  logic              out_written_r, out_written_nxt;
  logic              out_scrolled_r, out_scrolled_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              out_free, pop, wrap_line, scroll_go;
  logic [ROW_W-1:0]  cur_prow;
  logic [COL_W:0]    col_inc, col_tab, col_lim;
  logic [ADDR_W-1:0] blank_start;

  assign out_free    = !out_valid_r || !out_stall;
  assign q_stall     = !((state_r == S_RUN) && out_free);
  assign pop         = q_valid && !q_stall;
  assign clearing    = (state_r == S_CLEAR);

  assign cur_prow    = row_wrap({1'b0, cur_row_r} + {1'b0, base_r});
  assign col_inc     = {1'b0, cur_col_r} + (COL_W+1)'(1);
  assign col_tab     = {1'b0, cur_col_r} + (COL_W+1)'(TAB_STEP);
  assign col_lim     = (COL_W+1)'(COLUMNS);
  // the old top row becomes the new bottom row
  assign blank_start = cell_addr(base_r, '0);

  always_comb begin
    state_nxt        = state_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    base_nxt         = base_r;
    sweep_nxt        = sweep_r;
    end_nxt          = end_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    out_written_nxt  = out_written_r;
    out_scrolled_nxt = out_scrolled_r;
    mem_we           = 1'b0;
    mem_waddr        = sweep_r;
    mem_wdata        = {RESET_COLOR, CH_SPACE};
    mem_raddr        = cell_addr(row_wrap({1'b0, q_cmd.row} + {1'b0, base_r}), q_cmd.col);
    wrap_line        = 1'b0;
    scroll_go        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = ADDR_W'(sweep_r + 1'b1);
        if (sweep_r == end_r) begin
          state_nxt = S_RUN;
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color, CH_SPACE};
        sweep_nxt = ADDR_W'(sweep_r + 1'b1);
        if (sweep_r == end_r) begin
          state_nxt     = S_RUN;
          out_valid_nxt = 1'b1;
        end
      end
      S_READ: begin
        out_data_nxt  = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_RUN;
      end
      S_RUN: begin
        if (pop) begin
          out_data_nxt     = '0;
          out_written_nxt  = 1'b0;
          out_scrolled_nxt = 1'b0;
          out_valid_nxt    = 1'b1;
          unique case (q_cmd.kind)
            K_READ: begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_READ;
            end
            K_PRINT: begin
              mem_we          = 1'b1;
              mem_waddr       = cell_addr(cur_prow, cur_col_r);
              mem_wdata       = {text_color, q_cmd.char_code};
              out_data_nxt    = {text_color, q_cmd.char_code};
              out_written_nxt = 1'b1;
              if (col_inc >= col_lim) begin
                wrap_line = 1'b1;
              end else begin
                cur_col_nxt = COL_W'(col_inc);
              end
            end
            K_NEWLINE: wrap_line = 1'b1;
            K_RETURN:  cur_col_nxt = '0;
            K_TAB: begin
              if (col_tab >= col_lim) begin
                wrap_line = 1'b1;
              end else begin
                cur_col_nxt = COL_W'(col_tab);
              end
            end
            K_NOP, K_READ_OUT: ;
            default: ;
          endcase
          if (wrap_line) begin
            cur_col_nxt = '0;
            if (cur_row_r != ROW_W'(ROWS - 1)) begin
              cur_row_nxt = ROW_W'(cur_row_r + 1'b1);
            end else begin
              scroll_go        = 1'b1;
              out_scrolled_nxt = 1'b1;
              out_valid_nxt    = 1'b0;
              base_nxt         = row_wrap({1'b0, base_r} + (ROW_W+1)'(1));
              sweep_nxt        = blank_start;
              end_nxt          = blank_start + ADDR_W'(COLUMNS - 1);
              state_nxt        = S_BLANK;
            end
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      base_r      <= '0;
      sweep_r     <= '0;
      end_r       <= ADDR_W'(CELLS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      base_r      <= base_nxt;
      sweep_r     <= sweep_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r     <= out_data_nxt;
    out_written_r  <= out_written_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // cursor only moves on a pop, which needs the result register free
  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_data_r;
  assign out_cell_written  = out_written_r;
  assign out_cursor_column = COLF_W'(cur_col_r);
  assign out_cursor_row    = ROWF_W'(cur_row_r);
  assign out_scrolled      = out_scrolled_r;

  `TTW_ASSERT_ALWAYS(a_row_range, (32'(cur_row_r) < ROWS) && (32'(base_r) < ROWS), "row out of range")
  `TTW_ASSERT_IMP(a_pop_free, pop, out_free, "pop while result register busy")
  `TTW_ASSERT_NEXT(a_read_done, state_r == S_READ, out_valid_r, "read result not presented")
  `TTW_ASSERT_NEXT(a_scroll_blank, scroll_go, (state_r == S_BLANK) && !out_valid_r, "scroll without blank sweep")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ttw_pkg::*;

  typedef struct {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [COLF_W-1:0] rcol;
    logic [ROWF_W-1:0] rrow;
  } term_word_t;

  typedef struct {
    logic [CELL_W-1:0] data;
    logic              written;
    logic [COLF_W-1:0] col;
    logic [ROWF_W-1:0] row;
    logic              scrolled;
  } term_cell_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CHAR_W-1:0] cfg_text_color = RESET_COLOR;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [COLF_W-1:0] in_read_column = '0;
  logic [ROWF_W-1:0] in_read_row = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CELL_W-1:0] out_cell_data;
  logic              out_cell_written;
  logic [COLF_W-1:0] out_cursor_column;
  logic [ROWF_W-1:0] out_cursor_row;
  logic              out_scrolled;

  text_terminal_writer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_text_color   (cfg_text_color),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_read_column   (in_read_column),
    .in_read_row      (in_read_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_data    (out_cell_data),
    .out_cell_written (out_cell_written),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row   (out_cursor_row),
    .out_scrolled     (out_scrolled)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // screen image and cursor as the terminal should hold them
  logic [CELL_W-1:0] screen [CELLS];
  int                cursor_col;
  int                cursor_row;
  logic [CHAR_W-1:0] text_attr;

  term_word_t pending_words [$];
  term_cell_t cells_due [$];
  term_word_t word_on_bus;
  term_cell_t seen_cell;
  term_cell_t want_cell;

  int  errors = 0;
  int  results_checked = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  offering;

  // column 0 of the next row; on the last row the screen rolls up one row
  task automatic feed_line(output logic rolled);
    cursor_col = 0;
    rolled = 1'b0;
    if (cursor_row + 1 < ROWS) begin
      cursor_row++;
    end else begin
      rolled = 1'b1;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) screen[(ROWS - 1) * COLUMNS + c] = {text_attr, CH_SPACE};
    end
  endtask

  task automatic emulate_terminal_word(input term_word_t w);
    term_cell_t r;
    r = '{default: '0};
    if (w.op == OP_READ) begin
      if (w.rcol < COLUMNS && w.rrow < ROWS) r.data = screen[w.rrow * COLUMNS + w.rcol];
    end else begin
      case (w.ch)
        CH_LF: feed_line(r.scrolled);
        CH_CR: cursor_col = 0;
        CH_TAB: begin
          if (cursor_col + TAB_STEP >= COLUMNS) feed_line(r.scrolled);
          else cursor_col += TAB_STEP;
        end
        CH_NUL, CH_BEL: ;
        default: begin
          r.data = {text_attr, w.ch};
          r.written = 1'b1;
          screen[cursor_row * COLUMNS + cursor_col] = r.data;
          if (cursor_col + 1 >= COLUMNS) feed_line(r.scrolled);
          else cursor_col++;
        end
      endcase
    end
    r.col = COLF_W'(cursor_col);
    r.row = ROWF_W'(cursor_row);
    cells_due.push_back(r);
  endtask

  // fields a word does not use still get random bits
  function automatic void add_word(logic op, logic [CHAR_W-1:0] ch,
                                   logic [COLF_W-1:0] rcol, logic [ROWF_W-1:0] rrow);
    term_word_t w;
    w.op = op;
    w.ch = (op == OP_PUT) ? ch : CHAR_W'($urandom);
    w.rcol = (op == OP_READ) ? rcol : COLF_W'($urandom);
    w.rrow = (op == OP_READ) ? rrow : ROWF_W'($urandom);
    pending_words.push_back(w);
  endfunction

  task automatic queue_random_stream(input int n);
    int target;
    int line_len;
    int roll;
    logic [CHAR_W-1:0] ch;
    target = pending_words.size() + n;
    while (pending_words.size() < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        add_word(OP_READ, '0, COLF_W'($urandom_range(0, COLUMNS - 1)),
                 ROWF_W'($urandom_range(0, ROWS - 1)));
      end else if (roll < 15) begin
        add_word(OP_READ, '0, COLF_W'($urandom), ROWF_W'($urandom));
      end else if (roll < 19) begin
        add_word(OP_PUT, CHAR_W'($urandom), '0, '0);
      end else begin
        // mostly short lines so that the screen rolls often, now and then a long one that wraps
        line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
        for (int i = 0; i < line_len; i++) begin
          if ($urandom_range(0, 9) == 0) ch = CH_TAB;
          else if ($urandom_range(0, 5) == 0) ch = CHAR_W'($urandom_range(128, 255));
          else ch = CHAR_W'($urandom_range(32, 126));
          add_word(OP_PUT, ch, '0, '0);
        end
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
          add_word(OP_PUT, CH_CR, '0, '0);
          add_word(OP_PUT, CH_LF, '0, '0);
        end else if (roll != 1) begin
          add_word(OP_PUT, CH_LF, '0, '0);
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || cells_due.size() != 0);
  endtask

  task automatic write_color(input logic [CHAR_W-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_text_color <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_attr = c;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        emulate_terminal_word(word_on_bus);
        offering = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = (tx_calm || hold_cycles > 0) ? 0 : $urandom_range(0, 18);
      end else if (!offering && tx_gap > 0) begin
        tx_gap--;
      end
      if (!offering && tx_gap == 0 && pending_words.size() != 0) begin
        word_on_bus = pending_words.pop_front();
        in_operation <= word_on_bus.op;
        in_char_code <= word_on_bus.ch;
        in_read_column <= word_on_bus.rcol;
        in_read_row <= word_on_bus.rrow;
        offering = 1'b1;
      end
      in_valid <= offering;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_cell = '{out_cell_data, out_cell_written, out_cursor_column, out_cursor_row,
                      out_scrolled};
        if (cells_due.size() == 0) begin
          $error("result word with nothing expected: cell_data %h", seen_cell.data);
          errors++;
        end else begin
          want_cell = cells_due.pop_front();
          if (seen_cell.data !== want_cell.data) begin
            $error("cell_data: expected %h, got %h", want_cell.data, seen_cell.data);
            errors++;
          end
          if (seen_cell.written !== want_cell.written) begin
            $error("cell_written: expected %0d, got %0d", want_cell.written, seen_cell.written);
            errors++;
          end
          if (seen_cell.col !== want_cell.col) begin
            $error("cursor_column: expected %0d, got %0d", want_cell.col, seen_cell.col);
            errors++;
          end
          if (seen_cell.row !== want_cell.row) begin
            $error("cursor_row: expected %0d, got %0d", want_cell.row, seen_cell.row);
            errors++;
          end
          if (seen_cell.scrolled !== want_cell.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want_cell.scrolled, seen_cell.scrolled);
            errors++;
          end
        end
        results_checked <= results_checked + 1;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0) || (hold_cycles > 0);
    end
  end

  // one long back-pressure stretch so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_checked >= 300) begin
      hold_cycles <= 400;
      hold_done <= 1'b1;
    end
  end

  logic [CHAR_W-1:0] phase_colors [5];

  initial begin
    text_attr = RESET_COLOR;
    cursor_col = 0;
    cursor_row = 0;
    foreach (screen[i]) screen[i] = {RESET_COLOR, CH_SPACE};
    phase_colors = '{8'h00, 8'hFF, CHAR_W'($urandom), 8'h1F, CHAR_W'($urandom)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // corners and out-of-range reads on the blank screen
    add_word(OP_READ, '0, 7'd0, 5'd0);
    add_word(OP_READ, '0, 7'd79, 5'd24);
    add_word(OP_READ, '0, 7'd80, 5'd0);
    add_word(OP_READ, '0, 7'd0, 5'd25);
    add_word(OP_READ, '0, 7'd127, 5'd31);
    // every control code and the byte extremes
    add_word(OP_PUT, 8'hFF, '0, '0);
    add_word(OP_PUT, 8'h01, '0, '0);
    add_word(OP_PUT, CH_NUL, '0, '0);
    add_word(OP_PUT, CH_BEL, '0, '0);
    add_word(OP_PUT, CH_CR, '0, '0);
    add_word(OP_PUT, CH_TAB, '0, '0);
    add_word(OP_PUT, 8'h7E, '0, '0);
    add_word(OP_PUT, CH_SPACE, '0, '0);
    add_word(OP_PUT, 8'h80, '0, '0);
    add_word(OP_PUT, CH_LF, '0, '0);
    add_word(OP_READ, '0, 7'd0, 5'd0);
    add_word(OP_READ, '0, 7'd1, 5'd0);
    add_word(OP_READ, '0, 7'd4, 5'd0);
    add_word(OP_READ, '0, 7'd6, 5'd0);
    add_word(OP_READ, '0, 7'd2, 5'd0);
    wait_idle();

    foreach (phase_colors[p]) begin
      write_color(phase_colors[p]);
      queue_random_stream(200);
      wait_idle();
    end

    // let any last scroll blanking sweep finish before the final check
    repeat (100) @(posedge clk);
    if (cells_due.size() != 0) begin
      $error("%0d expected result words never arrived", cells_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
